>>> hdl/rfd_pkg.sv
// shared types, codes and helpers of the routed frame deframer
`timescale 1ns / 1ps

package rfd_pkg;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int DEST_W  = 2;
    localparam int PHASE_W = 3;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENSION = 3'd4;

    // field kinds
    localparam logic [KIND_W-1:0] KIND_DEV     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CMD     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LEN     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TAIL    = 3'd4;

    // destinations
    localparam logic [DEST_W-1:0] DEST_LOCAL     = 2'd0;
    localparam logic [DEST_W-1:0] DEST_CAMERA    = 2'd1;
    localparam logic [DEST_W-1:0] DEST_EXTENSION = 2'd2;
    localparam logic [DEST_W-1:0] DEST_NONE      = 2'd3;

    // configuration register set
    typedef struct packed {
        logic [BYTE_W-1:0] header_byte;
        logic [BYTE_W-1:0] tail_byte;
        logic [BYTE_W-1:0] local_id;
        logic [BYTE_W-1:0] camera_id;
        logic [BYTE_W-1:0] extension_id;
    } t_cfg;

    // one parsed result item
    typedef struct packed {
        logic [KIND_W-1:0] field_kind;
        logic [BYTE_W-1:0] field_value;
        logic [BYTE_W-1:0] payload_index;
        logic [DEST_W-1:0] destination;
        logic              frame_end;
        logic              frame_good;
    } t_res;

    // device id to destination, local over camera over extension
    function automatic logic [DEST_W-1:0] pick_route(input logic [BYTE_W-1:0] id,
                                                     input t_cfg cfg);
        logic [DEST_W-1:0] dest;
        if (id == cfg.local_id) begin
            dest = DEST_LOCAL;
        end else if (id == cfg.camera_id) begin
            dest = DEST_CAMERA;
        end else if (id == cfg.extension_id) begin
            dest = DEST_EXTENSION;
        end else begin
            dest = DEST_NONE;
        end
        return dest;
    endfunction

endpackage

>>> hdl/routed_frame_deframer_top.sv
// top level of the routed frame deframer
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata: rx_byte
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata, tuser, tlast: parsed field
//  cfg       in   i_cfg_we                        i_cfg_idx, i_cfg_data
//
// one byte is taken every cycle while s_axis_tready is high; its result is registered in the
// result register or the skid stage before m_axis shows it, and a hunted or header byte gives no item
// s_axis_tready falls only while the skid stage holds an item, i.e. after
// the output has stalled with two results waiting; it rises the cycle after
// m_axis moves again
// synchronous active-low reset, no clearing pass; configuration is taken
// in the cycle that i_cfg_we is high
`timescale 1ns / 1ps

module routed_frame_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // stream output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] field_value, [15:8] payload_index,
                                        // [17:16] destination, [18] frame_good
    output logic [2:0]  m_axis_tuser,   // [2:0] field_kind
    output logic        m_axis_tlast,   // frame_end
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import rfd_pkg::*;

    t_cfg w_cfg;
    t_res w_res;
    t_res w_out;
    logic w_res_valid;
    logic w_accept;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    // configuration registers
    rfd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // byte parser
    rfd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_byte      (s_axis_tdata),
        .i_cfg       (w_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // result register and skid stage
    rfd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_res_valid),
        .i_res       (w_res),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_res       (w_out)
    );

    // output packing
    assign m_axis_tdata = {5'd0, w_out.frame_good, w_out.destination,
                           w_out.payload_index, w_out.field_value};
    assign m_axis_tuser = w_out.field_kind;
    assign m_axis_tlast = w_out.frame_end;

endmodule

>>> hdl/rfd_cfg.sv
// configuration register file of the routed frame deframer
`timescale 1ns / 1ps

module rfd_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rfd_pkg::BYTE_W-1:0]     i_cfg_data,
    output rfd_pkg::t_cfg                  o_cfg
);
    import rfd_pkg::*;

    t_cfg r_cfg;

    // register writes, indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_byte  <= 8'd0;
            r_cfg.tail_byte    <= 8'd0;
            r_cfg.local_id     <= 8'd0;
            r_cfg.camera_id    <= 8'd1;
            r_cfg.extension_id <= 8'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HEADER:    r_cfg.header_byte  <= i_cfg_data;
                CFG_TAIL:      r_cfg.tail_byte    <= i_cfg_data;
                CFG_LOCAL:     r_cfg.local_id     <= i_cfg_data;
                CFG_CAMERA:    r_cfg.camera_id    <= i_cfg_data;
                CFG_EXTENSION: r_cfg.extension_id <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/rfd_parse.sv
// phase machine that parses one received byte per cycle while bytes are accepted
`timescale 1ns / 1ps

module rfd_parse (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [rfd_pkg::BYTE_W-1:0] i_byte,
    input  rfd_pkg::t_cfg              i_cfg,
    output logic                       o_res_valid,
    output rfd_pkg::t_res              o_res
);
    import rfd_pkg::*;

    localparam logic [PHASE_W-1:0] PH_HUNT    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_DEV     = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CMD     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LEN     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;
    localparam logic [PHASE_W-1:0] PH_TAIL    = 3'd5;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [BYTE_W-1:0]  r_bytes_left, n_bytes_left;
    logic [BYTE_W-1:0]  r_byte_position, n_byte_position;
    logic [DEST_W-1:0]  r_route, n_route;
    logic [DEST_W-1:0]  w_dest;

    // next state and result for the byte at the input
    always_comb begin
        n_phase         = r_phase;
        n_bytes_left    = r_bytes_left;
        n_byte_position = r_byte_position;
        n_route         = r_route;
        w_dest          = r_route;
        o_res_valid     = 1'b0;
        o_res.field_kind    = KIND_DEV;
        o_res.field_value   = i_byte;
        o_res.payload_index = '0;
        o_res.frame_end     = 1'b0;
        o_res.frame_good    = 1'b0;
        unique case (r_phase)
            PH_DEV: begin
                n_route     = pick_route(i_byte, i_cfg);
                w_dest      = n_route;
                o_res_valid = i_accept;
                n_phase     = PH_CMD;
            end
            PH_CMD: begin
                o_res.field_kind = KIND_CMD;
                o_res_valid      = i_accept;
                n_phase          = PH_LEN;
            end
            PH_LEN: begin
                o_res.field_kind = KIND_LEN;
                o_res_valid      = i_accept;
                n_bytes_left     = i_byte;
                n_byte_position  = '0;
                n_phase          = (i_byte != '0) ? PH_PAYLOAD : PH_TAIL;
            end
            PH_PAYLOAD: begin
                o_res.field_kind    = KIND_PAYLOAD;
                o_res.payload_index = r_byte_position;
                o_res_valid         = i_accept;
                n_byte_position     = r_byte_position + 8'd1;
                n_bytes_left        = r_bytes_left - 8'd1;
                if (r_bytes_left == 8'd1) begin
                    n_phase = PH_TAIL;
                end
            end
            PH_TAIL: begin
                o_res.field_kind = KIND_TAIL;
                o_res.frame_end  = 1'b1;
                o_res.frame_good = (i_byte == i_cfg.tail_byte);
                o_res_valid      = i_accept;
                n_phase          = PH_HUNT;
                n_bytes_left     = '0;
                n_byte_position  = '0;
            end
            default: begin
                // hunting, unused codes included
                n_phase = (i_byte == i_cfg.header_byte) ? PH_DEV : PH_HUNT;
            end
        endcase
        o_res.destination = w_dest;
    end

    // phase registers advance only on an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_HUNT;
            r_bytes_left    <= '0;
            r_byte_position <= '0;
            r_route         <= DEST_NONE;
        end else if (i_accept) begin
            r_phase         <= n_phase;
            r_bytes_left    <= n_bytes_left;
            r_byte_position <= n_byte_position;
            r_route         <= n_route;
        end
    end

    // payload phase always has bytes to go
    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_bytes_left != '0)
        else $error("payload phase with no bytes left");

    // hunting starts from cleared counters
    a_hunt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HUNT |-> (r_bytes_left == '0 && r_byte_position == '0))
        else $error("counters not cleared while hunting");

    // a tail item ends the frame
    a_tail_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_phase == PH_TAIL) |=> r_phase == PH_HUNT)
        else $error("no return to hunting after tail");

endmodule

>>> hdl/rfd_out_buf.sv
// result register with skid stage toward the output channel
`timescale 1ns / 1ps

module rfd_out_buf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  rfd_pkg::t_res i_res,
    input  logic          i_out_ready,
    output logic          o_in_ready,
    output logic          o_valid,
    output rfd_pkg::t_res o_res
);
    import rfd_pkg::*;

    logic r_out_valid;
    logic r_skid_valid;
    t_res r_out;
    t_res r_skid;
    logic w_out_fire;

    assign w_out_fire = r_out_valid && i_out_ready;
    assign o_in_ready = !r_skid_valid;

    // control of the two result slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_valid) begin
            if (r_out_valid && !w_out_fire) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out <= r_skid;
            end
        end else if (i_valid) begin
            if (r_out_valid && !w_out_fire) begin
                r_skid <= i_res;
            end else begin
                r_out <= i_res;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // skid only fills behind a waiting result
    a_skid_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot full with empty output slot");

    // a held skid item stays until the output moves
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !w_out_fire) |=> (r_skid_valid && $stable(r_skid)))
        else $error("skid item lost during stall");

    // an item into an empty buffer lands in the output slot
    a_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !r_out_valid && !r_skid_valid) |=> (r_out_valid && !r_skid_valid))
        else $error("item into empty buffer misplaced");

endmodule

>>> tb/rfd_field_checker.sv
// field checker: predicts parsed fields from accepted bytes and compares the output items
`timescale 1ns / 1ps

module rfd_field_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // [7:0] field_value, [15:8] payload_index,
                                        // [17:16] destination, [18] frame_good
    input  logic [2:0]  m_axis_tuser,   // [2:0] field_kind
    input  logic        m_axis_tlast,   // frame_end
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    import rfd_pkg::*;

    typedef enum logic [PHASE_W-1:0] {
        PH_HUNT,
        PH_DEV,
        PH_CMD,
        PH_LEN,
        PH_PAYLOAD,
        PH_TAIL
    } t_phase;

    // shadow of the registers and of the frame parser
    t_cfg              regs;
    t_phase            phase;
    logic [BYTE_W-1:0] bytes_left;
    logic [BYTE_W-1:0] next_index;
    logic [DEST_W-1:0] route;
    t_res              fields_due[$];
    int                errors = 0;

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic check_one(input string name, input int got, input int want);
        if (got != want) begin
            report($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    // register write, indexes past the list are dropped
    task automatic apply_write(input logic [2:0] idx, input logic [BYTE_W-1:0] value);
        case (idx)
            CFG_HEADER:    regs.header_byte  = value;
            CFG_TAIL:      regs.tail_byte    = value;
            CFG_LOCAL:     regs.local_id     = value;
            CFG_CAMERA:    regs.camera_id    = value;
            CFG_EXTENSION: regs.extension_id = value;
            default: ;
        endcase
    endtask

    // advance the frame parser by one byte and queue the field it yields
    task automatic parse_byte(input logic [BYTE_W-1:0] rx);
        t_res field;
        logic yields;
        field = '0;
        field.field_value = rx;
        yields = 1'b1;
        case (phase)
            PH_DEV: begin
                // route is latched here and held for the whole frame
                if (rx == regs.local_id) begin
                    route = DEST_LOCAL;
                end else if (rx == regs.camera_id) begin
                    route = DEST_CAMERA;
                end else if (rx == regs.extension_id) begin
                    route = DEST_EXTENSION;
                end else begin
                    route = DEST_NONE;
                end
                field.field_kind = KIND_DEV;
                phase = PH_CMD;
            end
            PH_CMD: begin
                field.field_kind = KIND_CMD;
                phase = PH_LEN;
            end
            PH_LEN: begin
                field.field_kind = KIND_LEN;
                bytes_left = rx;
                next_index = '0;
                phase = (rx != '0) ? PH_PAYLOAD : PH_TAIL;
            end
            PH_PAYLOAD: begin
                field.field_kind = KIND_PAYLOAD;
                field.payload_index = next_index;
                next_index = next_index + 1'b1;
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == '0) begin
                    phase = PH_TAIL;
                end
            end
            PH_TAIL: begin
                field.field_kind = KIND_TAIL;
                field.frame_end = 1'b1;
                field.frame_good = (rx == regs.tail_byte);
                phase = PH_HUNT;
                bytes_left = '0;
                next_index = '0;
            end
            default: begin
                // hunting: header and dropped bytes give no item
                yields = 1'b0;
                phase = (rx == regs.header_byte) ? PH_DEV : PH_HUNT;
            end
        endcase
        field.destination = route;
        if (yields) begin
            fields_due.push_back(field);
        end
    endtask

    task automatic compare_field(input t_res got);
        t_res want;
        want = fields_due.pop_front();
        check_one("field_kind", got.field_kind, want.field_kind);
        check_one("field_value", got.field_value, want.field_value);
        check_one("payload_index", got.payload_index, want.payload_index);
        check_one("destination", got.destination, want.destination);
        check_one("frame_end", got.frame_end, want.frame_end);
        check_one("frame_good", got.frame_good, want.frame_good);
    endtask

    // watch both channels and the register port
    always @(posedge i_clk) begin : observe
        t_res got;
        if (!i_rst_n) begin
            regs = '{header_byte: 8'h00, tail_byte: 8'h00, local_id: 8'h00,
                     camera_id: 8'h01, extension_id: 8'h02};
            phase = PH_HUNT;
            bytes_left = '0;
            next_index = '0;
            route = DEST_NONE;
            fields_due.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.field_kind    = m_axis_tuser;
                got.field_value   = m_axis_tdata[7:0];
                got.payload_index = m_axis_tdata[15:8];
                got.destination   = m_axis_tdata[17:16];
                got.frame_good    = m_axis_tdata[18];
                got.frame_end     = m_axis_tlast;
                if (fields_due.size() == 0) begin
                    report($sformatf("item with nothing expected, kind %0d value %0h",
                                     got.field_kind, got.field_value));
                end else begin
                    compare_field(got);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                parse_byte(s_axis_tdata);
            end
            if (i_cfg_we) begin
                apply_write(i_cfg_idx, i_cfg_data);
            end
        end
        o_pending <= fields_due.size();
        o_errors  <= errors;
    end

endmodule

>>> tb/tb_routed_frame_deframer_top.sv
// testbench top of the routed frame deframer: reset, byte stream, register writes, verdict
`timescale 1ns / 1ps

module tb_routed_frame_deframer_top;

    import rfd_pkg::*;

    // register indexes past the end of the list
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_EXTENSION + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 1750;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_we      = 1'b0;
    logic [2:0]  i_cfg_idx     = 3'd0;
    logic [7:0]  i_cfg_data    = 8'h00;

    int field_errors;
    int fields_pending;
    bit no_gaps = 1'b0;

    // register values as last written
    logic [7:0] cur_header    = 8'h00;
    logic [7:0] cur_tail      = 8'h00;
    logic [7:0] cur_local     = 8'h00;
    logic [7:0] cur_camera    = 8'h01;
    logic [7:0] cur_extension = 8'h02;

    routed_frame_deframer_top dut (.*);

    rfd_field_checker u_field_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (field_errors),
        .o_pending     (fields_pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // output side stalls at random
    always @(posedge i_clk) begin
        m_axis_tready <= no_gaps || ($urandom_range(99) >= 13);
    end

    // run limit
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // one byte item, with random gaps in front of it
    task automatic send_byte(input logic [7:0] value);
        while (!no_gaps && $urandom_range(99) < 13) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // stop the stream and wait until every field has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (fields_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_HEADER:    cur_header    = value;
            CFG_TAIL:      cur_tail      = value;
            CFG_LOCAL:     cur_local     = value;
            CFG_CAMERA:    cur_camera    = value;
            CFG_EXTENSION: cur_extension = value;
            default: ;
        endcase
    endtask

    // complete frame with random command and payload
    task automatic send_frame(input logic [7:0] dev, input int len, input bit tail_ok);
        send_byte(cur_header);
        send_byte(dev);
        send_byte(8'($urandom_range(255)));
        send_byte(len[7:0]);
        repeat (len) send_byte(8'($urandom_range(255)));
        send_byte(tail_ok ? cur_tail : 8'($urandom_range(255)));
    endtask

    // stimulus
    initial begin
        int items;
        int next_cfg;
        int len;
        int n;
        int mode;
        logic [7:0] dev;
        logic [7:0] id_a;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: dropped byte, camera frame with zero length
        send_byte(8'h55);
        send_frame(cur_camera, 0, 1'b1);
        drain();

        // local and camera share an id, write past the register list
        write_reg(CFG_HEADER, 8'hA5);
        write_reg(CFG_TAIL, 8'h5A);
        write_reg(CFG_LOCAL, 8'h10);
        write_reg(CFG_CAMERA, 8'h10);
        write_reg(CFG_EXTENSION, 8'h20);
        write_reg(CFG_SPARE_LO, 8'hFF);

        // local wins, payload extremes, tail mismatch
        send_byte(cur_header);
        send_byte(8'h10);
        send_byte(8'hFF);
        send_byte(8'd2);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);

        // extension frame, ids rewritten after the device id
        send_byte(cur_header);
        send_byte(8'h20);
        send_byte(8'h00);
        drain();
        write_reg(CFG_CAMERA, 8'h20);
        write_reg(CFG_EXTENSION, 8'h77);
        send_byte(8'd1);
        send_byte(8'h80);
        send_byte(cur_tail);

        // unknown id
        send_frame(8'hEE, 0, 1'b1);

        // random frames, noise and broken frames under changing settings
        items = 0;
        next_cfg = 0;
        while (items < RANDOM_ITEMS) begin
            no_gaps = (items >= 700 && items < 1000);
            if (items >= next_cfg) begin
                drain();
                mode = $urandom_range(3);
                if (mode == 0) begin
                    // all ones, every id the same
                    write_reg(CFG_HEADER, 8'hFF);
                    write_reg(CFG_TAIL, 8'hFF);
                    write_reg(CFG_LOCAL, 8'hFF);
                    write_reg(CFG_CAMERA, 8'hFF);
                    write_reg(CFG_EXTENSION, 8'hFF);
                end else if (mode == 1) begin
                    // all zeros
                    write_reg(CFG_HEADER, 8'h00);
                    write_reg(CFG_TAIL, 8'h00);
                    write_reg(CFG_LOCAL, 8'h00);
                    write_reg(CFG_CAMERA, 8'h00);
                    write_reg(CFG_EXTENSION, 8'h00);
                end else begin
                    id_a = 8'($urandom_range(255));
                    write_reg(CFG_HEADER, 8'($urandom_range(255)));
                    write_reg(CFG_TAIL, 8'($urandom_range(255)));
                    write_reg(CFG_LOCAL, 8'($urandom_range(255)));
                    // mode 3 lets camera and extension share an id
                    write_reg(CFG_CAMERA, id_a);
                    write_reg(CFG_EXTENSION, (mode == 3) ? id_a : 8'($urandom_range(255)));
                end
                write_reg(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                          8'($urandom_range(255)));
                next_cfg = items + $urandom_range(150, 350);
            end

            n = $urandom_range(99);
            if (n < 80) begin
                mode = $urandom_range(3);
                dev = (mode == 0) ? cur_local :
                      (mode == 1) ? cur_camera :
                      (mode == 2) ? cur_extension : 8'($urandom_range(255));
                n = $urandom_range(99);
                len = (n < 85) ? $urandom_range(6) :
                      (n < 98) ? $urandom_range(7, 40) : $urandom_range(200, 255);
                send_frame(dev, len, $urandom_range(99) < 85);
                items += len + 5;
            end else if (n < 90) begin
                // noise between frames, may start a frame by chance
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
            end else begin
                // header followed by a few stray bytes
                n = $urandom_range(1, 3);
                send_byte(cur_header);
                repeat (n) send_byte(8'($urandom_range(255)));
                items += n + 1;
            end
        end
        no_gaps = 1'b0;

        drain();
        if (field_errors == 0 && fields_pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/rfd_pkg.sv
hdl/rfd_cfg.sv
hdl/rfd_parse.sv
hdl/rfd_out_buf.sv
hdl/routed_frame_deframer_top.sv
tb/rfd_field_checker.sv
tb/tb_routed_frame_deframer_top.sv
